### src/mbs_pkg.sv
// ---------------------------------------------------------------------------
// mbs_pkg
// Shared types, codes and helpers for the maze backtracker step core.
// ---------------------------------------------------------------------------
`default_nettype none

package mbs_pkg;

  // Configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam int SIZE_W = 5;

  // Result action codes
  localparam logic [2:0] ACT_WEST  = 3'd0;
  localparam logic [2:0] ACT_EAST  = 3'd1;
  localparam logic [2:0] ACT_NORTH = 3'd2;
  localparam logic [2:0] ACT_SOUTH = 3'd3;
  localparam logic [2:0] ACT_BACK  = 3'd4;
  localparam logic [2:0] ACT_START = 3'd5;
  localparam logic [2:0] ACT_EMPTY = 3'd6;

  // Carve directions, same order as the candidate scan
  localparam logic [1:0] DIR_WEST  = 2'd0;
  localparam logic [1:0] DIR_EAST  = 2'd1;
  localparam logic [1:0] DIR_NORTH = 2'd2;
  localparam logic [1:0] DIR_SOUTH = 2'd3;

  // Stack operation chosen for a request
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_PUSH  = 2'd1;
  localparam logic [1:0] OP_POP   = 2'd2;
  localparam logic [1:0] OP_EMPTY = 2'd3;

  // Request kinds
  localparam logic KIND_START = 1'b0;

  typedef struct packed {
    logic [SIZE_W-1:0] w;   // clamped columns in use
    logic [SIZE_W-1:0] h;   // clamped rows in use
  } mbs_grid_t;

  typedef struct packed {
    logic [1:0] op;
    logic       push_room;
    logic       wall_east;
    logic       wall_south;
  } mbs_ctl_t;

  typedef struct packed {
    logic [2:0] action;
    logic [3:0] cell_x;
    logic [3:0] cell_y;
    logic [3:0] next_x;
    logic [3:0] next_y;
    logic       walk_done;
  } mbs_result_t;

  // v mod 3 by folding base-4 digits (4 == 1 mod 3)
  function automatic logic [1:0] mod3(input logic [7:0] v);
    logic [3:0] s;
    logic [2:0] t;
    logic [2:0] u;
    s = 4'(v[7:6]) + 4'(v[5:4]) + 4'(v[3:2]) + 4'(v[1:0]);
    t = 3'(s[3:2]) + 3'(s[1:0]);
    u = 3'(t[2]) + 3'(t[1:0]);
    if (u >= 3'd3) begin
      u = u - 3'd3;
    end
    return u[1:0];
  endfunction

  // Position of the k-th set bit of cand, scanning from bit 0
  function automatic logic [1:0] pick_dir(input logic [3:0] cand, input logic [1:0] k);
    logic [2:0] seen;
    logic [1:0] d;
    seen = '0;
    d    = '0;
    for (int i = 0; i < 4; i++) begin
      if (cand[i]) begin
        if (seen == {1'b0, k}) begin
          d = 2'(i);
        end
        seen = seen + 3'd1;
      end
    end
    return d;
  endfunction

endpackage

`default_nettype wire

### src/mbs_if.sv
// ---------------------------------------------------------------------------
// mbs request / result channels
// Valid/ready channels carrying walk requests and walk results.
// ---------------------------------------------------------------------------
`default_nettype none

interface mbs_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [3:0] start_x;
  logic [3:0] start_y;
  logic [7:0] random_pick;

  modport source (output valid, output kind, output start_x, output start_y,
                  output random_pick, input ready);
  modport sink   (input valid, input kind, input start_x, input start_y,
                  input random_pick, output ready);
endinterface

interface mbs_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [3:0] cell_x;
  logic [3:0] cell_y;
  logic [3:0] next_x;
  logic [3:0] next_y;
  logic       walk_done;

  modport source (output valid, output action, output cell_x, output cell_y,
                  output next_x, output next_y, output walk_done, input ready);
  modport sink   (input valid, input action, input cell_x, input cell_y,
                  input next_x, input next_y, input walk_done, output ready);
endinterface

`default_nettype wire

### src/mbs_ram.sv
// ---------------------------------------------------------------------------
// mbs_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module mbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

### src/mbs_cfg.sv
// ---------------------------------------------------------------------------
// mbs_cfg
// APB-style grid size registers with readback and size clamping.
// ---------------------------------------------------------------------------
`default_nettype none

module mbs_cfg
  import mbs_pkg::*;
#(
  parameter int GRID_SIDE = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output mbs_grid_t              grid
);

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  logic [SIZE_W-1:0] width_r, width_nxt;
  logic [SIZE_W-1:0] height_r, height_nxt;
  logic              wr_en;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    if (v == '0) begin
      return SIZE_W'(1);
    end
    if (int'(v) > GRID_SIDE) begin
      return SIZE_W'(GRID_SIDE);
    end
    return v;
  endfunction

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (wr_en) begin
      case (paddr[2])
        REG_WIDTH:  width_nxt  = pwdata[SIZE_W-1:0];
        REG_HEIGHT: height_nxt = pwdata[SIZE_W-1:0];
        default:    width_nxt  = width_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_W'(16);
      height_r <= SIZE_W'(16);
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_WIDTH:  prdata = {{(APB_DW-SIZE_W){1'b0}}, width_r};
      REG_HEIGHT: prdata = {{(APB_DW-SIZE_W){1'b0}}, height_r};
      default:    prdata = '0;
    endcase
  end

  assign grid.w = clamp_size(width_r);
  assign grid.h = clamp_size(height_r);

endmodule

`default_nettype wire

### src/mbs_step.sv
// ---------------------------------------------------------------------------
// mbs_step
// Per-request decision: neighbor scan, random pick, stack op and result.
// ---------------------------------------------------------------------------
`default_nettype none

module mbs_step
  import mbs_pkg::*;
#(
  parameter int GRID_SIDE = 16,
  parameter int CW        = $clog2(GRID_SIDE),
  parameter int CELLS     = GRID_SIDE * GRID_SIDE,
  parameter int IW        = $clog2(CELLS),
  parameter int CNTW      = $clog2(CELLS + 1)
) (
  input  wire logic             kind,
  input  wire logic [3:0]       start_x,
  input  wire logic [3:0]       start_y,
  input  wire logic [7:0]       random_pick,
  input  wire mbs_grid_t        grid,
  input  wire logic [CW-1:0]    top_x,
  input  wire logic [CW-1:0]    top_y,
  input  wire logic [CW-1:0]    under_x,
  input  wire logic [CW-1:0]    under_y,
  input  wire logic [CNTW-1:0]  count,
  input  wire logic [CELLS-1:0] visited,
  output mbs_ctl_t              ctl,
  output mbs_result_t           res,
  output logic      [CW-1:0]    new_x,
  output logic      [CW-1:0]    new_y,
  output logic      [IW-1:0]    mark_idx,
  output logic      [IW-1:0]    wall_idx
);

  localparam int CMPW = ((CW > SIZE_W) ? CW : SIZE_W) + 1;

  logic [CMPW-1:0] w_e, h_e, tx_e, ty_e, sx_e, sy_e;
  logic [3:0]      cand;
  logic [2:0]      n_cand;
  logic [1:0]      k_pick;
  logic [1:0]      dir;
  logic [CW-1:0]   cx_x, cx_y;
  logic [1:0]      step_op;
  logic            room;
  logic            wall_e;
  logic            wall_s;

  function automatic logic [IW-1:0] idx(input logic [CW-1:0] x, input logic [CW-1:0] y);
    return IW'(int'(y) * GRID_SIDE + int'(x));
  endfunction

  function automatic logic [3:0] crd4(input logic [CW-1:0] c);
    logic [CMPW-1:0] e;
    e = CMPW'(c);
    return e[3:0];
  endfunction

  assign w_e  = CMPW'(grid.w);
  assign h_e  = CMPW'(grid.h);
  assign tx_e = CMPW'(top_x);
  assign ty_e = CMPW'(top_y);

  // start cell clamped to the grid in use
  always_comb begin
    sx_e = CMPW'(start_x);
    sy_e = CMPW'(start_y);
    if (sx_e > w_e - CMPW'(1)) begin
      sx_e = w_e - CMPW'(1);
    end
    if (sy_e > h_e - CMPW'(1)) begin
      sy_e = h_e - CMPW'(1);
    end
  end

  // unvisited neighbors: west, east, north, south
  assign cand[0] = (top_x != '0) ? !visited[idx(CW'(top_x - CW'(1)), top_y)] : 1'b0;
  assign cand[1] = (tx_e + CMPW'(1) < w_e) ?
                   !visited[idx(CW'(top_x + CW'(1)), top_y)] : 1'b0;
  assign cand[2] = (top_y != '0) ? !visited[idx(top_x, CW'(top_y - CW'(1)))] : 1'b0;
  assign cand[3] = (ty_e + CMPW'(1) < h_e) ?
                   !visited[idx(top_x, CW'(top_y + CW'(1)))] : 1'b0;

  assign n_cand = 3'($countones(cand));

  always_comb begin
    case (n_cand)
      3'd2:    k_pick = {1'b0, random_pick[0]};
      3'd3:    k_pick = mod3(random_pick);
      3'd4:    k_pick = random_pick[1:0];
      default: k_pick = 2'd0;
    endcase
  end

  assign dir = pick_dir(cand, k_pick);

  // carve target and wall
  always_comb begin
    cx_x     = top_x;
    cx_y     = top_y;
    wall_e   = 1'b0;
    wall_s   = 1'b0;
    wall_idx = idx(top_x, top_y);
    case (dir)
      DIR_WEST: begin
        cx_x     = CW'(top_x - CW'(1));
        wall_e   = 1'b1;
        wall_idx = idx(CW'(top_x - CW'(1)), top_y);
      end
      DIR_EAST: begin
        cx_x     = CW'(top_x + CW'(1));
        wall_e   = 1'b1;
      end
      DIR_NORTH: begin
        cx_y     = CW'(top_y - CW'(1));
        wall_s   = 1'b1;
        wall_idx = idx(top_x, CW'(top_y - CW'(1)));
      end
      default: begin
        cx_y     = CW'(top_y + CW'(1));
        wall_s   = 1'b1;
      end
    endcase
  end

  always_comb begin
    room = (count < CNTW'(CELLS));
    if (kind == KIND_START) begin
      step_op = OP_START;
    end else if (count == '0 || count > CNTW'(CELLS)) begin
      step_op = OP_EMPTY;
    end else if (n_cand == 3'd0) begin
      step_op = OP_POP;
    end else begin
      step_op = OP_PUSH;
    end
  end

  assign ctl = '{op: step_op, push_room: room, wall_east: wall_e, wall_south: wall_s};

  always_comb begin
    new_x = cx_x;
    new_y = cx_y;
    res   = '0;
    case (step_op)
      OP_START: begin
        new_x          = CW'(sx_e);
        new_y          = CW'(sy_e);
        res.action     = ACT_START;
        res.cell_x     = crd4(CW'(sx_e));
        res.cell_y     = crd4(CW'(sy_e));
        res.next_x     = crd4(CW'(sx_e));
        res.next_y     = crd4(CW'(sy_e));
        res.walk_done  = 1'b0;
      end
      OP_PUSH: begin
        res.action     = {1'b0, dir};
        res.cell_x     = crd4(top_x);
        res.cell_y     = crd4(top_y);
        res.next_x     = crd4(cx_x);
        res.next_y     = crd4(cx_y);
        res.walk_done  = 1'b0;
      end
      OP_POP: begin
        res.action     = ACT_BACK;
        res.cell_x     = crd4(top_x);
        res.cell_y     = crd4(top_y);
        if (count > CNTW'(1)) begin
          res.next_x   = crd4(under_x);
          res.next_y   = crd4(under_y);
        end
        res.walk_done  = (count == CNTW'(1));
      end
      default: begin
        res.action     = ACT_EMPTY;
        res.walk_done  = 1'b1;
      end
    endcase
  end

  assign mark_idx = idx(new_x, new_y);

endmodule

`default_nettype wire

### src/maze_backtracker_step_core.sv
// ---------------------------------------------------------------------------
// maze_backtracker_step_core
// Randomized depth-first maze generator, one walk step per request.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch  : walk requests (kind 0 = start at start_x/start_y, 1 = one step;
//            random_pick chooses among unvisited neighbors).
//   out_ch : one result per request (action, handled cell, next cell,
//            walk_done).
//   psel/penable/pwrite/paddr/pwdata/prdata/pready : grid_width at 0x0,
//            grid_height at 0x4. Write only while the core is idle.
// Timing:
//   One request per cycle sustained while out_ch.ready is high. A result
//   is shown in the cycle after its request is taken. The step is a single
//   pass over flop-held visited bits and a top/under cell pair; the path
//   stack below those sits in a RAM whose registered read is issued on each pop.
// Reset (rst_n low, synchronous): stack empty, visited and wall bits clear,
//   grid 16 x 16, no result pending. No clearing pass is needed.
// Back-pressure: the result register holds while out_ch.ready is low, and a
//   new request is taken only when that register is empty or draining.
// ---------------------------------------------------------------------------
`default_nettype none

module maze_backtracker_step_core
  import mbs_pkg::*;
#(
  parameter int GRID_SIDE = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  mbs_in_if.sink                 in_ch,
  mbs_out_if.source              out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  localparam int CW    = $clog2(GRID_SIDE);
  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int IW    = $clog2(CELLS);
  localparam int CNTW  = $clog2(CELLS + 1);
  localparam int PW    = 2 * CW;       // packed cell {y, x}

  mbs_grid_t   grid;
  mbs_ctl_t    ctl;
  mbs_result_t res;

  logic             acc;

  // walk state
  logic [CNTW-1:0]  count_r, count_nxt;
  logic [PW-1:0]    top_r, top_nxt;        // stack top, always in flops
  logic [PW-1:0]    under_r, under_nxt;    // entry below top after a push
  logic             under_sel_r, under_sel_nxt;  // 1: under_r holds it, 0: RAM
  logic [PW-1:0]    under;
  logic [CELLS-1:0] visited_r, visited_nxt;
  logic [CELLS-1:0] east_r, east_nxt;
  logic [CELLS-1:0] south_r, south_nxt;

  // result register
  logic             out_valid_r, out_valid_nxt;
  mbs_result_t      out_r;

  // stack RAM
  logic             ram_we, ram_re;
  logic [PW-1:0]    ram_rdata;
  logic [CNTW-1:0]  cnt_m1, cnt_m3;

  logic [CW-1:0]    new_x, new_y;
  logic [IW-1:0]    mark_idx, wall_idx;
  logic [IW-1:0]    top_idx;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;

  // Config registers
  mbs_cfg #(.GRID_SIDE(GRID_SIDE)) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .grid    (grid)
  );

  // Entry under the top: just pushed -> flop copy, after a pop -> RAM read.
  assign under = under_sel_r ? under_r : ram_rdata;

  // Step decision
  mbs_step #(
    .GRID_SIDE (GRID_SIDE),
    .CW        (CW),
    .CELLS     (CELLS),
    .IW        (IW),
    .CNTW      (CNTW)
  ) u_step (
    .kind        (in_ch.kind),
    .start_x     (in_ch.start_x),
    .start_y     (in_ch.start_y),
    .random_pick (in_ch.random_pick),
    .grid        (grid),
    .top_x       (top_r[CW-1:0]),
    .top_y       (top_r[PW-1:CW]),
    .under_x     (under[CW-1:0]),
    .under_y     (under[PW-1:CW]),
    .count       (count_r),
    .visited     (visited_r),
    .ctl         (ctl),
    .res         (res),
    .new_x       (new_x),
    .new_y       (new_y),
    .mark_idx    (mark_idx),
    .wall_idx    (wall_idx)
  );

  // Stack RAM holds entries 0 .. count-2; the top lives in top_r.
  // A push spills the old top at count-1; a pop fetches the new under
  // entry at count-3 so it is ready for the following request.
  assign cnt_m1 = count_r - CNTW'(1);
  assign cnt_m3 = count_r - CNTW'(3);
  assign ram_we = acc && (ctl.op == OP_PUSH) && ctl.push_room;
  assign ram_re = acc && (ctl.op == OP_POP);

  mbs_ram #(.WIDTH(PW), .DEPTH(CELLS)) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_m1[IW-1:0]),
    .wdata (top_r),
    .re    (ram_re),
    .raddr (cnt_m3[IW-1:0]),
    .rdata (ram_rdata)
  );

  // Next-state update
  always_comb begin
    count_nxt     = count_r;
    top_nxt       = top_r;
    under_nxt     = under_r;
    under_sel_nxt = under_sel_r;
    visited_nxt   = visited_r;
    east_nxt      = east_r;
    south_nxt     = south_r;
    if (acc) begin
      case (ctl.op)
        OP_START: begin
          visited_nxt           = '0;
          visited_nxt[mark_idx] = 1'b1;
          east_nxt              = '0;
          south_nxt             = '0;
          count_nxt             = CNTW'(1);
          top_nxt               = {new_y, new_x};
        end
        OP_PUSH: begin
          visited_nxt[mark_idx] = 1'b1;
          if (ctl.wall_east) begin
            east_nxt[wall_idx] = 1'b1;
          end
          if (ctl.wall_south) begin
            south_nxt[wall_idx] = 1'b1;
          end
          if (ctl.push_room) begin
            count_nxt     = count_r + CNTW'(1);
            top_nxt       = {new_y, new_x};
            under_nxt     = top_r;
            under_sel_nxt = 1'b1;
          end
        end
        OP_POP: begin
          count_nxt     = cnt_m1;
          top_nxt       = under;
          under_sel_nxt = 1'b0;
        end
        default: begin
          count_nxt = '0;
        end
      endcase
    end
  end

  // Result register: loads on accept, drains on out ready
  always_comb begin
    if (acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      under_sel_r <= 1'b0;
      visited_r   <= '0;
      east_r      <= '0;
      south_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      under_sel_r <= under_sel_nxt;
      visited_r   <= visited_nxt;
      east_r      <= east_nxt;
      south_r     <= south_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    top_r   <= top_nxt;
    under_r <= under_nxt;
    if (acc) begin
      out_r <= res;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.action    = out_r.action;
  assign out_ch.cell_x    = out_r.cell_x;
  assign out_ch.cell_y    = out_r.cell_y;
  assign out_ch.next_x    = out_r.next_x;
  assign out_ch.next_y    = out_r.next_y;
  assign out_ch.walk_done = out_r.walk_done;

  // top cell index, for checking only
  assign top_idx = IW'(int'(top_r[PW-1:CW]) * GRID_SIDE + int'(top_r[CW-1:0]));

  // Assertions
  a_start_count: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_ch.kind == KIND_START) |=> count_r == CNTW'(1))
    else $error("stack depth not one after start");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNTW'(CELLS))
    else $error("stack depth beyond cell count");

  a_top_visited: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != '0 |-> visited_r[top_idx])
    else $error("stack top cell not marked visited");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("request taken while result stalled");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid_r)
    else $error("accepted request produced no result");

endmodule

`default_nettype wire
